// ===== sv/mvrm_pkg.sv =====
// Shared constants, command codes, control structs and helper functions of the mixer.
package mvrm_pkg;

	localparam int VOICES        = 8;
	localparam int VOICE_SAMPLES = 8192;
	localparam int MAX_CHANNELS  = 8;

	localparam int VOICE_W = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam int SAMP_W  = $clog2(VOICE_SAMPLES);
	localparam int MEM_W   = VOICE_W + SAMP_W;
	localparam int MEM_D   = VOICES * VOICE_SAMPLES;
	localparam int CH_W    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int CHN_W   = 4;
	localparam int POS_W   = 30;
	localparam int GAIN_W  = 15;
	localparam int ACC_W   = 48 + VOICE_W;
	localparam int END_W   = 19;

	localparam logic [POS_W-1:0]  POS_LIMIT  = {POS_W{1'b1}};
	localparam logic [GAIN_W-1:0] UNITY_GAIN = GAIN_W'(4096);

	// Command codes
	localparam logic [2:0] CMD_WRITE  = 3'd0;
	localparam logic [2:0] CMD_SETUP  = 3'd1;
	localparam logic [2:0] CMD_PLAY   = 3'd2;
	localparam logic [2:0] CMD_PAUSE  = 3'd3;
	localparam logic [2:0] CMD_GAIN   = 3'd4;
	localparam logic [2:0] CMD_RENDER = 3'd5;

	// Sample format codes
	localparam logic [1:0] FMT_8  = 2'd0;
	localparam logic [1:0] FMT_16 = 2'd1;

	// Register indexes
	localparam logic REG_CHANNELS = 1'b0;
	localparam logic REG_FORMAT   = 1'b1;

	// Controller to datapath commands
	typedef struct packed {
		logic exec;
		logic clr_acc;
		logic k_rst;
		logic k_inc;
		logic c_rst;
		logic c_inc;
		logic vload;
		logic rd_a;
		logic rd_b;
		logic mul;
		logic interp;
		logic gain;
		logic acc;
		logic adv;
		logic out_load;
	} mvrm_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic voice_ok;
		logic last_voice;
		logic ch_last;
		logic ch_more;
		logic out_free;
	} mvrm_sts_t;

	// Clamp a channel count into 1..MAX_CHANNELS
	function automatic logic [CHN_W-1:0] clamp_ch(input logic [CHN_W-1:0] c);
		logic [CHN_W-1:0] r;
		r = c;
		if (c == '0) r = CHN_W'(1);
		else if (c > CHN_W'(MAX_CHANNELS)) r = CHN_W'(MAX_CHANNELS);
		return r;
	endfunction

	// Normalise a stored word to a full-scale signed 32-bit value
	function automatic logic signed [31:0] norm(input logic [31:0] raw, input logic [1:0] fmt);
		logic signed [31:0] r;
		r = $signed(raw);
		if (fmt == FMT_8) r = $signed({raw[7:0], 24'd0});
		else if (fmt == FMT_16) r = $signed({raw[15:0], 16'd0});
		return r;
	endfunction

endpackage

// ===== sv/mvrm_ctrl.sv =====
// Controller state machine sequencing commands and the render walk.
module mvrm_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic [2:0]         cmd,
	input  mvrm_pkg::mvrm_sts_t sts,
	output logic               in_stall,
	output mvrm_pkg::mvrm_cmd_t ctl
);
	import mvrm_pkg::*;

	typedef enum logic [9:0] {
		ST_IDLE   = 10'b0000000001,
		ST_VOICE  = 10'b0000000010,
		ST_RDA    = 10'b0000000100,
		ST_RDB    = 10'b0000001000,
		ST_MUL    = 10'b0000010000,
		ST_INTERP = 10'b0000100000,
		ST_GAIN   = 10'b0001000000,
		ST_ACC    = 10'b0010000000,
		ST_ADV    = 10'b0100000000,
		ST_OUT    = 10'b1000000000
	} state_t;

	state_t state_q, state_d;
	logic   accept;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		ctl     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (cmd == CMD_RENDER) begin
						ctl.clr_acc = 1'b1;
						ctl.k_rst   = 1'b1;
						state_d     = ST_VOICE;
					end else begin
						ctl.exec = 1'b1;
					end
				end
			end
			ST_VOICE: begin
				ctl.vload = 1'b1;
				ctl.c_rst = 1'b1;
				if (sts.voice_ok) begin
					state_d = ST_RDA;
				end else if (sts.last_voice) begin
					state_d = ST_OUT;
				end else begin
					ctl.k_inc = 1'b1;
				end
			end
			ST_RDA: begin
				ctl.rd_a = 1'b1;
				state_d  = ST_RDB;
			end
			ST_RDB: begin
				ctl.rd_b = 1'b1;
				state_d  = ST_MUL;
			end
			ST_MUL: begin
				ctl.mul = 1'b1;
				state_d = ST_INTERP;
			end
			ST_INTERP: begin
				ctl.interp = 1'b1;
				state_d    = ST_GAIN;
			end
			ST_GAIN: begin
				ctl.gain = 1'b1;
				state_d  = ST_ACC;
			end
			ST_ACC: begin
				ctl.acc = 1'b1;
				if (sts.ch_last) begin
					state_d = ST_ADV;
				end else begin
					ctl.c_inc = 1'b1;
					if (sts.ch_more) state_d = ST_RDA;
				end
			end
			ST_ADV: begin
				ctl.adv = 1'b1;
				if (sts.last_voice) begin
					ctl.c_rst = 1'b1;
					state_d   = ST_OUT;
				end else begin
					ctl.k_inc = 1'b1;
					state_d   = ST_VOICE;
				end
			end
			ST_OUT: begin
				if (sts.out_free) begin
					ctl.out_load = 1'b1;
					if (sts.ch_last) state_d = ST_IDLE;
					else ctl.c_inc = 1'b1;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

endmodule

// ===== sv/mvrm_dp.sv =====
// Datapath: sample memory, voice registers, interpolator, accumulators and output register.
module mvrm_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  mvrm_pkg::mvrm_cmd_t ctl,
	input  logic [2:0]          cmd,
	input  logic [2:0]          voice,
	input  logic [12:0]         addr,
	input  logic signed [31:0]  sample,
	input  logic [1:0]          src_format,
	input  logic [3:0]          src_channels,
	input  logic [13:0]         src_frames,
	input  logic [31:0]         rate_step,
	input  logic signed [15:0]  gain,
	input  logic [3:0]          dev_channels,
	input  logic [1:0]          dev_format,
	input  logic                out_stall,
	output mvrm_pkg::mvrm_sts_t sts,
	output logic                out_valid,
	output logic signed [31:0]  out_sample,
	output logic [2:0]          out_channel,
	output logic                last
);
	import mvrm_pkg::*;

	// Voice state
	logic [31:0]       step_q   [VOICES];
	logic [POS_W-1:0]  pos_q    [VOICES];
	logic [13:0]       frames_q [VOICES];
	logic [CHN_W-1:0]  vch_q    [VOICES];
	logic [1:0]        fmt_q    [VOICES];
	logic [GAIN_W-1:0] gain_q   [VOICES];
	logic [VOICES-1:0] active_q;

	// Sample memory
	logic [31:0] mem [MEM_D];
	logic [31:0] rdata_q;

	// Walk registers
	logic [VOICE_W-1:0] k_q;
	logic [CH_W-1:0]    c_q;
	logic [SAMP_W-1:0]  base_q;
	logic [CHN_W-1:0]   vc_q;
	logic [15:0]        f_q;
	logic [GAIN_W-1:0]  vg_q;
	logic [1:0]         vf_q;
	logic signed [31:0] na_q;
	logic signed [49:0] prod_q;
	logic signed [31:0] prev_q;
	logic signed [47:0] gprod_q;
	logic signed [ACC_W-1:0] acc_q [MAX_CHANNELS];

	logic [31:0]        out_sample_q;
	logic [2:0]         out_channel_q;
	logic               last_q;
	logic               out_valid_q;

	logic               vsel;
	logic [13:0]        a_c;
	logic [14:0]        b_c;
	logic [END_W-1:0]   end_c;
	logic [END_W-1:0]   base_c;
	logic [CHN_W-1:0]   cur_vch;
	logic [CHN_W-1:0]   dch;
	logic [CHN_W-1:0]   c_next;
	logic [SAMP_W-1:0]  off;
	logic [MEM_W-1:0]   rd_idx;
	logic               we;
	logic signed [31:0] nb_n;
	logic signed [32:0] diff;
	logic signed [49:0] prod_sh;
	logic [32:0]        np;
	logic signed [ACC_W-1:0] shifted;
	logic signed [ACC_W-1:0] y;
	logic signed [ACC_W-1:0] hi;
	logic signed [ACC_W-1:0] lo;

	assign vsel = ({29'd0, voice} < 32'(VOICES));

	assign dch    = clamp_ch(dev_channels);
	assign c_next = CHN_W'(c_q) + CHN_W'(1);

	// Current voice geometry, end check and walk status
	always_comb begin
		cur_vch = vch_q[k_q];
		a_c     = pos_q[k_q][POS_W-1:16];
		b_c     = {1'b0, a_c} + 15'd1;
		base_c  = END_W'(a_c) * END_W'(cur_vch);
		end_c   = END_W'(b_c) * END_W'(cur_vch) + END_W'(cur_vch);
		sts.voice_ok   = active_q[k_q] && (b_c < {1'b0, frames_q[k_q]}) &&
			(end_c <= END_W'(VOICE_SAMPLES));
		sts.last_voice = (k_q == VOICE_W'(VOICES - 1));
		sts.ch_last    = (c_next == dch);
		sts.ch_more    = (c_next < vc_q);
		sts.out_free   = !out_valid_q || !out_stall;
	end

	// Read address of frame a or frame b
	always_comb begin
		off = base_q + SAMP_W'(c_q);
		if (ctl.rd_b) off = off + SAMP_W'(vc_q);
		rd_idx = {k_q, off};
	end

	assign we = ctl.exec && (cmd == CMD_WRITE) && vsel &&
		({19'd0, addr} < 32'(VOICE_SAMPLES));

	// Sample memory port
	always_ff @(posedge clk) begin
		if (we) mem[{voice[VOICE_W-1:0], addr[SAMP_W-1:0]}] <= sample;
		if (ctl.rd_a || ctl.rd_b) rdata_q <= mem[rd_idx];
	end

	// Advance position with saturation
	assign np = {3'd0, pos_q[k_q]} + {1'b0, step_q[k_q]};

	// Voice registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < VOICES; i++) begin
				step_q[i]   <= '0;
				pos_q[i]    <= '0;
				frames_q[i] <= '0;
				vch_q[i]    <= CHN_W'(1);
				fmt_q[i]    <= FMT_16;
				gain_q[i]   <= UNITY_GAIN;
			end
			active_q <= '0;
		end else begin
			if (ctl.exec && vsel) begin
				unique case (cmd)
					CMD_SETUP: begin
						fmt_q[voice[VOICE_W-1:0]]    <= src_format;
						vch_q[voice[VOICE_W-1:0]]    <= clamp_ch(src_channels);
						frames_q[voice[VOICE_W-1:0]] <= src_frames;
						step_q[voice[VOICE_W-1:0]]   <= rate_step;
						pos_q[voice[VOICE_W-1:0]]    <= '0;
						gain_q[voice[VOICE_W-1:0]]   <= UNITY_GAIN;
						active_q[voice[VOICE_W-1:0]] <= 1'b0;
					end
					CMD_PLAY:  active_q[voice[VOICE_W-1:0]] <= 1'b1;
					CMD_PAUSE: active_q[voice[VOICE_W-1:0]] <= 1'b0;
					CMD_GAIN: begin
						gain_q[voice[VOICE_W-1:0]] <= gain[15] ? '0 : gain[GAIN_W-1:0];
					end
					default: ;
				endcase
			end
			if (ctl.adv) begin
				pos_q[k_q] <= (np > {3'd0, POS_LIMIT}) ? POS_LIMIT : np[POS_W-1:0];
			end
		end
	end

	// Walk counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
			c_q <= '0;
		end else begin
			if (ctl.k_rst) k_q <= '0;
			else if (ctl.k_inc) k_q <= k_q + VOICE_W'(1);
			if (ctl.c_rst) c_q <= '0;
			else if (ctl.c_inc) c_q <= c_q + CH_W'(1);
		end
	end

	assign nb_n    = norm(rdata_q, vf_q);
	assign diff    = {nb_n[31], nb_n} - {na_q[31], na_q};
	assign prod_sh = prod_q >>> 16;

	// Interpolation and gain pipeline
	always_ff @(posedge clk) begin
		if (ctl.vload) begin
			base_q <= base_c[SAMP_W-1:0];
			vc_q   <= cur_vch;
			f_q    <= pos_q[k_q][15:0];
			vg_q   <= gain_q[k_q];
			vf_q   <= fmt_q[k_q];
		end
		if (ctl.rd_b) na_q <= nb_n;
		if (ctl.mul) prod_q <= diff * $signed({1'b0, f_q});
		if (ctl.interp) prev_q <= na_q + $signed(prod_sh[31:0]);
		if (ctl.gain) gprod_q <= prev_q * $signed({1'b0, vg_q});
		if (ctl.clr_acc) begin
			for (int i = 0; i < MAX_CHANNELS; i++) acc_q[i] <= '0;
		end else if (ctl.acc) begin
			acc_q[c_q] <= acc_q[c_q] + ACC_W'(gprod_q);
		end
	end

	// Scale and saturate to the device width
	always_comb begin
		if (dev_format == FMT_8) begin
			shifted = acc_q[c_q] >>> 36;
			hi = ACC_W'(127);
		end else if (dev_format == FMT_16) begin
			shifted = acc_q[c_q] >>> 28;
			hi = ACC_W'(32767);
		end else begin
			shifted = acc_q[c_q] >>> 12;
			hi = ACC_W'(64'sh7FFFFFFF);
		end
		lo = -hi - ACC_W'(1);
		y = shifted;
		if (shifted > hi) y = hi;
		else if (shifted < lo) y = lo;
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			out_sample_q  <= y[31:0];
			out_channel_q <= 3'(c_q);
			last_q        <= sts.ch_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_sample  = $signed(out_sample_q);
	assign out_channel = out_channel_q;
	assign last        = last_q;

endmodule

// ===== sv/multi_voice_resampling_mixer.sv =====
// Top level: configuration port, controller and datapath of the resampling mixer.
// Non-render commands leave the controller idle, so the next item is accepted in the following cycle.
// Render walks every voice; per playing voice it reads frames a and b, multiplies, interpolates,
// applies gain and accumulates per channel read, accumulates again per repeated device channel
// and advances; it then loads one output per device channel. Output stalls add to the walk.
// Reset clears the controller, voice registers and configuration; sample memory is not cleared.
module multi_voice_resampling_mixer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         cmd,
	input  logic [2:0]         voice,
	input  logic [12:0]        addr,
	input  logic signed [31:0] sample,
	input  logic [1:0]         src_format,
	input  logic [3:0]         src_channels,
	input  logic [13:0]        src_frames,
	input  logic [31:0]        rate_step,
	input  logic signed [15:0] gain,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] out_sample,
	output logic [2:0]         out_channel,
	output logic               last,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	import mvrm_pkg::*;

	logic [3:0] dev_channels_q;
	logic [1:0] dev_format_q;
	mvrm_cmd_t  ctl;
	mvrm_sts_t  sts;
	logic [3:0] dch_m1;

	assign pready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_channels_q <= 4'd2;
			dev_format_q   <= FMT_16;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				REG_CHANNELS: dev_channels_q <= pwdata[3:0];
				REG_FORMAT:   dev_format_q   <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	// Register read back
	always_comb begin
		unique case (paddr[2])
			REG_CHANNELS: prdata = {28'd0, dev_channels_q};
			REG_FORMAT:   prdata = {30'd0, dev_format_q};
			default:      prdata = '0;
		endcase
	end

	mvrm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.cmd      (cmd),
		.sts      (sts),
		.in_stall (in_stall),
		.ctl      (ctl)
	);

	mvrm_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.cmd          (cmd),
		.voice        (voice),
		.addr         (addr),
		.sample       (sample),
		.src_format   (src_format),
		.src_channels (src_channels),
		.src_frames   (src_frames),
		.rate_step    (rate_step),
		.gain         (gain),
		.dev_channels (dev_channels_q),
		.dev_format   (dev_format_q),
		.out_stall    (out_stall),
		.sts          (sts),
		.out_valid    (out_valid),
		.out_sample   (out_sample),
		.out_channel  (out_channel),
		.last         (last)
	);

	assign dch_m1 = clamp_ch(dev_channels_q) - 4'd1;

	// A render item keeps the input side busy in the next cycle
	a_render_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && cmd == CMD_RENDER |=> in_stall)
		else $error("render did not hold input");

	// Other commands finish at once
	a_cmd_quick: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && cmd != CMD_RENDER |=> !in_stall)
		else $error("command held input");

	// The frame closes on the last device channel
	a_last_chan: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> {1'b0, out_channel} == dch_m1)
		else $error("last on wrong channel");

endmodule
